[src/rxfc_pkg.sv]
// Shared types, register codes and reset values for the receive FIFO flow control block.
`default_nettype none
package rxfc_pkg;

	// Default FIFO depth in entries.
	localparam int FIFO_DEPTH_DEF = 64;

	// Configuration port widths.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Empty-read counter width and its saturation value.
	localparam int ERC_W = 17;
	localparam logic [ERC_W-1:0] ERC_MAX = {ERC_W{1'b1}};

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_XOFF_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_XON_DELAY      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_XOFF_CODE      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_XON_CODE       = 2'd3;

	// Register reset values.
	localparam logic [6:0]  XOFF_THRESHOLD_RST = 7'd5;
	localparam logic [15:0] XON_DELAY_RST      = 16'd260;
	localparam logic [7:0]  XOFF_CODE_RST      = 8'd19;
	localparam logic [7:0]  XON_CODE_RST       = 8'd17;

	// Input opcodes.
	localparam logic OP_RECEIVE = 1'b0;
	localparam logic OP_READ    = 1'b1;

	// Configuration register set.
	typedef struct packed {
		logic [6:0]  xoff_threshold;
		logic [15:0] xon_delay;
		logic [7:0]  xoff_code;
		logic [7:0]  xon_code;
	} cfg_t;

	// Result flags of one word, without the popped byte.
	typedef struct packed {
		logic       read_ok;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       rx_error_seen;
		logic       overflow;
	} res_t;

endpackage
`default_nettype wire

[src/rxfc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module rxfc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port; data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[src/rxfc_ctrl.sv]
// FIFO pointers, fill count, empty-read counter and per-word result decode.
`default_nettype none
module rxfc_ctrl #(
	parameter int FIFO_DEPTH = rxfc_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire logic           opcode,
	input  wire logic [7:0]     rx_byte,
	input  wire logic           line_error,
	input  wire rxfc_pkg::cfg_t cfg,
	output rxfc_pkg::res_t      res,
	output logic [7:0]          rd_data
);
	import rxfc_pkg::*;

	localparam int PW   = $clog2(FIFO_DEPTH);
	localparam int CW   = $clog2(FIFO_DEPTH + 1);
	localparam int CMPW = (CW > 7) ? CW : 7;
	localparam logic [PW-1:0] PTR_LAST = PW'(FIFO_DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(FIFO_DEPTH);

	logic [PW-1:0]    head_q;
	logic [PW-1:0]    tail_q;
	logic [CW-1:0]    count_q;
	logic [ERC_W-1:0] erc_q;

	logic             is_read;
	logic             full;
	logic             push;
	logic             pop;
	logic [CW-1:0]    count_after;
	logic             xoff_hit;
	logic             xon_due;
	logic [ERC_W-1:0] erc_next;
	logic [7:0]       push_data;

	// Decode the word against the current state.
	always_comb begin
		is_read     = (opcode == OP_READ);
		full        = (count_q == CNT_FULL);
		push        = !is_read && !full;
		pop         = is_read && (count_q != '0);
		push_data   = line_error ? 8'd0 : rx_byte;
		count_after = push ? count_q + CW'(1) : count_q;
		xoff_hit    = !is_read &&
			(CMPW'(count_after) == CMPW'(cfg.xoff_threshold));
		xon_due     = is_read && (erc_q > {1'b0, cfg.xon_delay});

		// Empty-read counter: cleared on a pop, restarted after an XON.
		if (pop) begin
			erc_next = '0;
		end else if (xon_due) begin
			erc_next = ERC_W'(1);
		end else if (erc_q != ERC_MAX) begin
			erc_next = erc_q + ERC_W'(1);
		end else begin
			erc_next = erc_q;
		end

		res.read_ok       = pop;
		res.tx_valid      = xoff_hit || xon_due;
		res.tx_byte       = xoff_hit ? cfg.xoff_code : (xon_due ? cfg.xon_code : 8'd0);
		res.rx_error_seen = !is_read && line_error;
		res.overflow      = !is_read && full;
	end

	// State update on each accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			erc_q   <= '0;
		end else if (accept) begin
			count_q <= push ? count_q + CW'(1) : (pop ? count_q - CW'(1) : count_q);
			if (push) begin
				tail_q <= (tail_q == PTR_LAST) ? '0 : tail_q + PW'(1);
			end
			if (pop) begin
				head_q <= (head_q == PTR_LAST) ? '0 : head_q + PW'(1);
			end
			if (is_read) begin
				erc_q <= erc_next;
			end
		end
	end

	// FIFO storage; a pop reads the head entry alongside the state update.
	rxfc_ram #(
		.WIDTH(8),
		.DEPTH(FIFO_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (accept && push),
		.waddr(tail_q),
		.wdata(push_data),
		.re   (accept && pop),
		.raddr(head_q),
		.rdata(rd_data)
	);

endmodule
`default_nettype wire

[src/rx_fifo_xon_xoff_flow_control_core.sv]
// Receive FIFO with XON/XOFF flow control: top level.
//
// Usage:
//   The slave stream takes one word per event. s_tuser[0] is the opcode
//   (0 = received character, 1 = host read attempt), s_tuser[1] flags a line
//   error on the character, and s_tdata[7:0] is the received character.
//   Every accepted word yields exactly one master word carrying the read
//   result, a possible XON or XOFF character to transmit and the error and
//   overflow flags.
//   The configuration channel writes the threshold, XON delay and the two
//   flow control codes; write it only while no word is in flight.
//   One word is taken per cycle while s_tready is high: the FIFO update and the
//   threshold and delay compares complete in the accept cycle, and the RAM
//   read of the head entry is registered and lands in the result stage.
//   A result stage and an output register sit between the two sides, so one
//   result may wait in the output while the next is in flight; when the
//   receiver stalls, s_tready falls once both are occupied.
//   Reset clears the pointers, counts and valid flags and sets the configuration
//   registers to their defaults; the FIFO storage needs no clearing because
//   entries are read only after they are written.
`default_nettype none
module rx_fifo_xon_xoff_flow_control_core #(
	parameter int FIFO_DEPTH = rxfc_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	input  wire logic [7:0]                      s_tdata,   // [7:0] rx_byte
	input  wire logic [1:0]                      s_tuser,   // [0] opcode, [1] line_error
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// [0] read_ok, [8:1] read_byte, [9] tx_valid, [17:10] tx_byte,
	// [18] rx_error_seen, [19] overflow, [23:20] zero
	output logic [23:0]                          m_tdata,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [rxfc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [rxfc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rxfc_pkg::*;

	cfg_t       cfg_q;
	res_t       res;
	res_t       res_s1;
	logic       valid_s1;
	logic [7:0] rd_data;
	logic       s_accept;
	logic       move_s1;
	logic       out_valid_q;
	logic [23:0] out_data_q;
	logic [7:0] read_byte_s1;

	// Configuration registers; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.xoff_threshold <= XOFF_THRESHOLD_RST;
			cfg_q.xon_delay      <= XON_DELAY_RST;
			cfg_q.xoff_code      <= XOFF_CODE_RST;
			cfg_q.xon_code       <= XON_CODE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_XOFF_THRESHOLD: cfg_q.xoff_threshold <= cfg_data[6:0];
				REG_XON_DELAY:      cfg_q.xon_delay      <= cfg_data;
				REG_XOFF_CODE:      cfg_q.xoff_code      <= cfg_data[7:0];
				REG_XON_CODE:       cfg_q.xon_code       <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Handshake between input, result stage and output register.
	assign move_s1  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || move_s1;
	assign s_accept = s_tvalid && s_tready;

	rxfc_ctrl #(
		.FIFO_DEPTH(FIFO_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (s_accept),
		.opcode    (s_tuser[0]),
		.rx_byte   (s_tdata),
		.line_error(s_tuser[1]),
		.cfg       (cfg_q),
		.res       (res),
		.rd_data   (rd_data)
	);

	// Result stage; the popped byte arrives from the RAM in this cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			res_s1 <= res;
		end
	end

	assign read_byte_s1 = res_s1.read_ok ? rd_data : 8'd0;

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			out_data_q <= {4'd0, res_s1.overflow, res_s1.rx_error_seen, res_s1.tx_byte,
				res_s1.tx_valid, read_byte_s1, res_s1.read_ok};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// A read result never carries receive-side flags.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[18] && !m_tdata[19])
		else $error("read result carries receive flags");

	// A byte is reported only on a successful read.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == 8'd0)
		else $error("read byte set without read_ok");

	// The input is open whenever the output register is free.
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> s_tready)
		else $error("input stalled with empty output");

	// A word accepted into an empty pipeline passes the result stage and reaches the output.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && !valid_s1 && !out_valid_q |=> ##1 m_tvalid)
		else $error("result lost in pipeline");

endmodule
`default_nettype wire

[verif/rx_fifo_xon_xoff_flow_control_core_test.sv]
// Self-checking testbench for the receive FIFO with XON/XOFF flow control.
`timescale 1ns / 100ps
`default_nettype none
module rx_fifo_xon_xoff_flow_control_core_test;
	import rxfc_pkg::*;

	localparam int DEPTH = FIFO_DEPTH_DEF;
	localparam int IDLE_LIMIT = 3000;
	localparam int LONG_HOLD = 200;

	// One result word; the first member lands in the highest bit.
	typedef struct packed {
		logic       overflow;
		logic       rx_error_seen;
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic [7:0] read_byte;
		logic       read_ok;
	} fc_word_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Shadow state of the flow control logic.
	logic [7:0] fifo_model [DEPTH];
	int         model_head;
	int         model_tail;
	int         model_fill;
	int         model_empty_reads;
	cfg_t       model_cfg;

	fc_word_t expected_words [$];
	int       mismatch_count;
	int       idle_cycles;

	// Sender and receiver idling controls.
	bit gaps_on;
	bit stalls_on;
	int burst_left;
	int hold_len;
	int pattern_left;
	logic [15:0] stall_pattern;

	rx_fifo_xon_xoff_flow_control_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Computes the result of one input word and advances the shadow FIFO.
	function automatic fc_word_t predict_word(logic op, logic [7:0] rx, logic err);
		fc_word_t res;
		res = '0;
		if (op == OP_RECEIVE) begin
			res.rx_error_seen = err;
			if (model_fill >= DEPTH) begin
				res.overflow = 1'b1;
			end else begin
				// A character with a line error is stored as zero.
				fifo_model[model_tail] = err ? 8'h00 : rx;
				model_tail = (model_tail + 1) % DEPTH;
				model_fill++;
			end
			if (model_fill == int'(model_cfg.xoff_threshold)) begin
				res.tx_valid = 1'b1;
				res.tx_byte = model_cfg.xoff_code;
			end
		end else begin
			if (model_empty_reads > int'(model_cfg.xon_delay)) begin
				res.tx_valid = 1'b1;
				res.tx_byte = model_cfg.xon_code;
				model_empty_reads = 0;
			end
			if (model_fill > 0) begin
				res.read_ok = 1'b1;
				res.read_byte = fifo_model[model_head];
				model_head = (model_head + 1) % DEPTH;
				model_fill--;
				model_empty_reads = 0;
			end else if (model_empty_reads < int'(ERC_MAX)) begin
				model_empty_reads++;
			end
		end
		return res;
	endfunction

	// Sends one word on the slave stream, with bursts and gaps when enabled.
	task automatic send_word(logic op, logic [7:0] rx, logic err);
		if (gaps_on && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		s_tvalid <= 1'b1;
		s_tdata <= rx;
		s_tuser <= {err, op};
		do @(posedge clk); while (!s_tready);
		expected_words.push_back(predict_word(op, rx, err));
		if (burst_left > 0) burst_left--;
		@(negedge clk);
	endtask

	// Lowers the stream valid and waits until every expected word has arrived.
	task automatic wait_results_done();
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_words.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Writes one register and mirrors it into the shadow configuration.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_XOFF_THRESHOLD: model_cfg.xoff_threshold = value[6:0];
			REG_XON_DELAY: model_cfg.xon_delay = value;
			REG_XOFF_CODE: model_cfg.xoff_code = value[7:0];
			REG_XON_CODE: model_cfg.xon_code = value[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Writes all four registers; upper data bits of the threshold and code writes are filled with noise.
	task automatic write_all(int thr, int delay, int xoff, int xon);
		write_reg(REG_XOFF_THRESHOLD, {9'($urandom), 7'(thr)});
		write_reg(REG_XON_DELAY, 16'(delay));
		write_reg(REG_XOFF_CODE, {8'($urandom), 8'(xoff)});
		write_reg(REG_XON_CODE, {8'($urandom), 8'(xon)});
	endtask

	// Random traffic with a given share of received characters.
	task automatic run_traffic(int count, int rx_pct, bit gaps, bit stalls);
		logic op;
		gaps_on = gaps;
		stalls_on = stalls;
		for (int i = 0; i < count; i++) begin
			op = ($urandom_range(0, 99) < rx_pct) ? OP_RECEIVE : OP_READ;
			send_word(op, 8'($urandom), $urandom_range(0, 5) == 0);
		end
	endtask

	// Register defaults: error substitution, XOFF at five, pops in order.
	task automatic test_defaults();
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		send_word(OP_READ, 8'hFF, 1'b1);
		send_word(OP_RECEIVE, 8'hFF, 1'b0);
		send_word(OP_RECEIVE, 8'h00, 1'b0);
		send_word(OP_RECEIVE, 8'hA5, 1'b1);
		send_word(OP_RECEIVE, 8'h5A, 1'b0);
		send_word(OP_RECEIVE, 8'h81, 1'b0);
		send_word(OP_RECEIVE, 8'h7E, 1'b0);
		for (int i = 0; i < 6; i++) send_word(OP_READ, 8'($urandom), i[0]);
		send_word(OP_READ, 8'h00, 1'b0);
		wait_results_done();
	endtask

	// XON due on a read, alone and together with a pop; XOFF with a zero code.
	task automatic test_xon_with_pop();
		write_all(1, 0, 'h00, 'hFF);
		send_word(OP_READ, 8'h00, 1'b0);
		send_word(OP_READ, 8'h00, 1'b0);
		send_word(OP_RECEIVE, 8'h3C, 1'b0);
		send_word(OP_READ, 8'hFF, 1'b1);
		send_word(OP_READ, 8'h00, 1'b0);
		wait_results_done();
	endtask

	// Threshold at full depth: overflow and repeated XOFF, plus a long output stall.
	task automatic test_full_fifo();
		write_all(DEPTH, 2, $urandom, $urandom);
		run_traffic(40, 85, 1'b0, 1'b1);
		// Receiver holds off while the sender keeps offering words.
		hold_len = LONG_HOLD;
		run_traffic(110, 85, 1'b0, 1'b0);
		run_traffic(70, 15, 1'b1, 1'b1);
		wait_results_done();
	endtask

	// Thresholds that never match: zero, one above depth and the field maximum.
	task automatic test_unreachable_threshold();
		write_all(0, 0, $urandom, $urandom);
		run_traffic(60, 50, 1'b1, 1'b1);
		wait_results_done();
		write_all(DEPTH + 1, 1, $urandom, $urandom);
		run_traffic(90, 85, 1'b1, 1'b0);
		run_traffic(40, 20, 1'b0, 1'b1);
		wait_results_done();
		write_reg(REG_XOFF_THRESHOLD, 16'hFFFF);
		run_traffic(30, 60, 1'b1, 1'b1);
		wait_results_done();
	endtask

	// Random settings with mostly small thresholds, some up to the depth, and short XON delays.
	task automatic test_random_settings();
		int thr;
		for (int p = 0; p < 5; p++) begin
			thr = ($urandom_range(0, 3) == 0) ? $urandom_range(1, DEPTH) : $urandom_range(1, 10);
			write_all(thr, $urandom_range(0, 8), $urandom, $urandom);
			run_traffic(30, $urandom_range(35, 65), p[0], p != 2);
			// The sender pauses once mid-phase until all results are in.
			if (p == 3) wait_results_done();
			run_traffic(30, $urandom_range(35, 65), 1'($urandom_range(0, 1)), 1'b1);
			wait_results_done();
		end
	endtask

	// Largest XON delay, then back to the reset values.
	task automatic test_long_delay();
		write_all(3, 'hFFFF, 'hFF, 'h00);
		run_traffic(30, 30, 1'b1, 1'b1);
		wait_results_done();
		write_all(int'(XOFF_THRESHOLD_RST), int'(XON_DELAY_RST), int'(XOFF_CODE_RST),
			int'(XON_CODE_RST));
		run_traffic(40, 50, 1'b1, 1'b1);
		wait_results_done();
	endtask

	// Receiver: long hold on request, otherwise a rotating stall pattern.
	always begin : receiver
		@(negedge clk);
		if (hold_len != 0) begin
			m_tready <= 1'b0;
			repeat (hold_len) @(negedge clk);
			hold_len = 0;
		end
		if (!stalls_on) begin
			m_tready <= 1'b1;
		end else begin
			if (pattern_left == 0) begin
				stall_pattern = ($urandom_range(0, 1) != 0) ? 16'($urandom | $urandom) : 16'($urandom);
				pattern_left = 16;
			end
			pattern_left--;
			m_tready <= stall_pattern[pattern_left];
		end
	end

	// Compares each accepted result word with the oldest expectation.
	always @(posedge clk) begin
		fc_word_t got;
		fc_word_t exp_word;
		if (m_tvalid && m_tready) begin
			got = m_tdata[19:0];
			if (expected_words.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected word: %06h", m_tdata);
			end else begin
				exp_word = expected_words.pop_front();
				if (got.read_ok !== exp_word.read_ok || got.read_byte !== exp_word.read_byte ||
					got.tx_valid !== exp_word.tx_valid || got.tx_byte !== exp_word.tx_byte ||
					got.rx_error_seen !== exp_word.rx_error_seen ||
					got.overflow !== exp_word.overflow || m_tdata[23:20] !== 4'h0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"word mismatch: expected ok=%b byte=%02h tx=%b/%02h ",
							"err=%b ovf=%b, got ok=%b byte=%02h tx=%b/%02h ",
							"err=%b ovf=%b pad=%h"},
							exp_word.read_ok, exp_word.read_byte, exp_word.tx_valid,
							exp_word.tx_byte, exp_word.rx_error_seen, exp_word.overflow,
							got.read_ok, got.read_byte, got.tx_valid, got.tx_byte,
							got.rx_error_seen, got.overflow, m_tdata[23:20]);
				end
			end
		end
	end

	// Watchdog: ends the run when no handshake completes for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Reset, then the tests in turn, then the verdict.
	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = 8'h00;
		s_tuser = 2'b00;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_XOFF_THRESHOLD;
		cfg_data = '0;
		mismatch_count = 0;
		idle_cycles = 0;
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		burst_left = 0;
		hold_len = 0;
		pattern_left = 0;
		model_head = 0;
		model_tail = 0;
		model_fill = 0;
		model_empty_reads = 0;
		model_cfg = '{XOFF_THRESHOLD_RST, XON_DELAY_RST, XOFF_CODE_RST, XON_CODE_RST};
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_defaults();
		test_xon_with_pop();
		test_full_fifo();
		test_unreachable_threshold();
		test_random_settings();
		test_long_delay();

		wait_results_done();
		repeat (10) @(negedge clk);
		if (mismatch_count == 0 && expected_words.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
`default_nettype wire

[filelist.f]
src/rxfc_pkg.sv
src/rxfc_ram.sv
src/rxfc_ctrl.sv
src/rx_fifo_xon_xoff_flow_control_core.sv
verif/rx_fifo_xon_xoff_flow_control_core_test.sv
